// ===== sv/wf23_pkg.sv =====
// ----------------------------------------------------------------------------
// wf23_pkg
// Shared types, widths and saturation helpers for the Winograd F(2x2,3x3)
// convolution tile engine.
// ----------------------------------------------------------------------------
package wf23_pkg;

   localparam int DATA_W   = 16;
   localparam int ACC_W    = 48;
   localparam int ROW_W    = DATA_W + 1;
   localparam int COL_W    = DATA_W + 2;
   localparam int PROD_W   = COL_W + DATA_W;
   localparam int TILE_N   = 4;
   localparam int ACC_N    = TILE_N * TILE_N;
   localparam int XF_W     = ACC_W + 2;
   localparam int OSUM_W   = ACC_W + 4;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [ROW_W-1:0]  row_type;
   typedef logic signed [COL_W-1:0]  col_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W:0]    acc_sum_type;
   typedef logic signed [XF_W-1:0]   xf_type;
   typedef logic signed [OSUM_W-1:0] osum_type;
   typedef logic [1:0]               row_idx_type;

   localparam row_idx_type LAST_ROW = row_idx_type'(TILE_N - 1);

   localparam acc_type ACC_MAX = acc_type'({1'b0, {(ACC_W-1){1'b1}}});
   localparam acc_type ACC_MIN = acc_type'({1'b1, {(ACC_W-1){1'b0}}});

   typedef struct packed {
      data_type sample_0;
      data_type sample_1;
      data_type sample_2;
      data_type sample_3;
      data_type weight_0;
      data_type weight_1;
      data_type weight_2;
      data_type weight_3;
      acc_type  bias;
      logic     last_slice;
   } req_type;

   typedef struct packed {
      acc_type out_00;
      acc_type out_01;
      acc_type out_10;
      acc_type out_11;
   } rsp_type;

   function automatic acc_type sat_acc_sum(input acc_sum_type v);
      acc_type res;
      if (v[ACC_W] != v[ACC_W-1]) begin
         res = v[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         res = v[ACC_W-1:0];
      end
      return res;
   endfunction

   function automatic acc_type sat_out_sum(input osum_type v);
      logic [OSUM_W-ACC_W:0] top;
      acc_type               res;
      top = v[OSUM_W-1:ACC_W-1];
      if ((top == '0) || (top == '1)) begin
         res = v[ACC_W-1:0];
      end else begin
         res = v[OSUM_W-1] ? ACC_MIN : ACC_MAX;
      end
      return res;
   endfunction

endpackage

// ===== sv/wf23_out_xform.sv =====
// ----------------------------------------------------------------------------
// wf23_out_xform
// Output transform At.M.A plus bias over a finished 4x4 accumulator tile,
// in three registered stages with per-stage flow control.
// ----------------------------------------------------------------------------
module wf23_out_xform
   import wf23_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tile_valid,
   output logic    tile_ready,
   input  acc_type tile_acc [ACC_N],
   input  acc_type tile_bias,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    c_valid_ff;
   acc_type c_acc_ff [ACC_N];
   acc_type c_bias_ff;

   logic    d_valid_ff;
   xf_type  d_t_ff [2][TILE_N];
   xf_type  d_t_in [2][TILE_N];
   acc_type d_bias_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic    e_ready;
   logic    d_ready;
   logic    c_ready;

   assign e_ready    = !rsp_valid_ff || rsp_ready;
   assign d_ready    = !d_valid_ff || e_ready;
   assign c_ready    = !c_valid_ff || d_ready;
   assign tile_ready = c_ready;

   // row reduction: At.M
   always_comb begin
      for (int c = 0; c < TILE_N; c++) begin
         d_t_in[0][c] = xf_type'(c_acc_ff[c]) + xf_type'(c_acc_ff[TILE_N + c])
                      + xf_type'(c_acc_ff[2*TILE_N + c]);
         d_t_in[1][c] = xf_type'(c_acc_ff[TILE_N + c]) - xf_type'(c_acc_ff[2*TILE_N + c])
                      - xf_type'(c_acc_ff[3*TILE_N + c]);
      end
   end

   // column reduction: (At.M).A plus bias
   always_comb begin
      osum_type s00, s01, s10, s11;
      s00 = osum_type'(d_bias_ff) + osum_type'(d_t_ff[0][0])
          + osum_type'(d_t_ff[0][1]) + osum_type'(d_t_ff[0][2]);
      s01 = osum_type'(d_bias_ff) + osum_type'(d_t_ff[0][1])
          - osum_type'(d_t_ff[0][2]) - osum_type'(d_t_ff[0][3]);
      s10 = osum_type'(d_bias_ff) + osum_type'(d_t_ff[1][0])
          + osum_type'(d_t_ff[1][1]) + osum_type'(d_t_ff[1][2]);
      s11 = osum_type'(d_bias_ff) + osum_type'(d_t_ff[1][1])
          - osum_type'(d_t_ff[1][2]) - osum_type'(d_t_ff[1][3]);
      rsp_in.out_00 = sat_out_sum(s00);
      rsp_in.out_01 = sat_out_sum(s01);
      rsp_in.out_10 = sat_out_sum(s10);
      rsp_in.out_11 = sat_out_sum(s11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= tile_valid;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_ready) begin
            rsp_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && tile_valid) begin
         c_acc_ff  <= tile_acc;
         c_bias_ff <= tile_bias;
      end
      if (d_ready && c_valid_ff) begin
         d_t_ff    <= d_t_in;
         d_bias_ff <= c_bias_ff;
      end
      if (e_ready && d_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/winograd_f23_conv_tile.sv =====
// ----------------------------------------------------------------------------
// winograd_f23_conv_tile
// Winograd F(2x2,3x3) convolution tile engine for one output channel.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one 4-sample row of a 4x4 input tile and the
//   matching row of pre-transformed weights per request. Every fourth
//   request completes a slice and is multiplied and accumulated into the
//   16-entry accumulator; when that request has last_slice set, the tile
//   is finished and one rsp request carries the 2x2 output, bias added and
//   saturated to 48 bits. last_slice on the first three rows is ignored.
//   Throughput: one request per cycle while the transform stages accept
//   finished tiles, set by the single registered multiply-accumulate
//   pass (16 parallel multipliers). A finishing request passes the input
//   and product registers and the transform stages before rsp_valid rises.
//   Reset clears the row counter, the accumulator and all valid flags; the
//   block is ready in the first cycle after reset.
//   A stalled rsp channel holds its result while up to two more finished
//   tiles queue in the transform stages; row requests keep flowing until a
//   finishing request finds the transform stages full.
// ----------------------------------------------------------------------------
module winograd_f23_conv_tile
   import wf23_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic        a_valid_ff;
   req_type     a_req_ff;
   logic        a_ready;
   logic        a_move;

   row_idx_type row_cnt_ff;
   row_type     rs_ff [TILE_N-1][TILE_N];
   data_type    ws_ff [TILE_N-1][TILE_N];

   logic        b_valid_ff;
   logic        b_valid_in;
   logic        b_last_ff;
   acc_type     b_bias_ff;
   prod_type    b_prod_ff [ACC_N];
   prod_type    b_prod_in [ACC_N];
   logic        b_ready;
   logic        b_move;
   logic        b_tile;

   acc_type     acc_ff [ACC_N];
   acc_type     acc_in [ACC_N];
   acc_type     acc_sum [ACC_N];

   logic        tile_ready;

   data_type    s [TILE_N];
   data_type    w [TILE_N];
   row_type     r [TILE_N];

   assign b_tile     = b_valid_ff && b_last_ff;
   assign b_ready    = !b_tile || tile_ready;
   assign b_move     = b_valid_ff && b_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign a_move     = a_valid_ff && b_ready;
   assign req_ready  = a_ready;
   assign b_valid_in = a_move && (row_cnt_ff == LAST_ROW);

   // row pass d.B and, on the fourth row, column pass and products
   always_comb begin
      s[0] = a_req_ff.sample_0;
      s[1] = a_req_ff.sample_1;
      s[2] = a_req_ff.sample_2;
      s[3] = a_req_ff.sample_3;
      w[0] = a_req_ff.weight_0;
      w[1] = a_req_ff.weight_1;
      w[2] = a_req_ff.weight_2;
      w[3] = a_req_ff.weight_3;
      r[0] = row_type'(s[0]) - row_type'(s[2]);
      r[1] = row_type'(s[1]) + row_type'(s[2]);
      r[2] = row_type'(s[2]) - row_type'(s[1]);
      r[3] = row_type'(s[1]) - row_type'(s[3]);
      for (int c = 0; c < TILE_N; c++) begin
         col_type col [TILE_N];
         col[0] = col_type'(rs_ff[0][c]) - col_type'(rs_ff[2][c]);
         col[1] = col_type'(rs_ff[1][c]) + col_type'(rs_ff[2][c]);
         col[2] = col_type'(rs_ff[2][c]) - col_type'(rs_ff[1][c]);
         col[3] = col_type'(rs_ff[1][c]) - col_type'(r[c]);
         for (int i = 0; i < TILE_N - 1; i++) begin
            b_prod_in[i*TILE_N + c] = prod_type'(col[i]) * prod_type'(ws_ff[i][c]);
         end
         b_prod_in[(TILE_N-1)*TILE_N + c] = prod_type'(col[TILE_N-1]) * prod_type'(w[c]);
      end
   end

   // saturating accumulate; clear on a finished tile
   always_comb begin
      for (int k = 0; k < ACC_N; k++) begin
         acc_sum[k] = sat_acc_sum(acc_sum_type'(acc_ff[k]) + acc_sum_type'(b_prod_ff[k]));
         acc_in[k]  = b_last_ff ? '0 : acc_sum[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         row_cnt_ff <= '0;
         for (int k = 0; k < ACC_N; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         if (a_ready) begin
            a_valid_ff <= req_valid;
         end
         if (b_ready) begin
            b_valid_ff <= b_valid_in;
         end
         if (a_move) begin
            row_cnt_ff <= row_cnt_ff + 2'd1;
         end
         if (b_move) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_valid) begin
         a_req_ff <= req_payload;
      end
      if (a_move && (row_cnt_ff != LAST_ROW)) begin
         for (int i = 0; i < TILE_N - 1; i++) begin
            if (row_cnt_ff == row_idx_type'(i)) begin
               rs_ff[i] <= r;
               ws_ff[i] <= w;
            end
         end
      end
      if (b_valid_in) begin
         b_prod_ff <= b_prod_in;
         b_last_ff <= a_req_ff.last_slice;
         b_bias_ff <= a_req_ff.bias;
      end
   end

   wf23_out_xform u_out_xform (
      .clock       (clock),
      .reset       (reset),
      .tile_valid  (b_tile),
      .tile_ready  (tile_ready),
      .tile_acc    (acc_sum),
      .tile_bias   (b_bias_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/tb_winograd_f23_conv_tile.sv =====
// ----------------------------------------------------------------------------
// tb_winograd_f23_conv_tile
// Self-checking bench for the Winograd F(2x2,3x3) tile engine. A tracker
// class mirrors the row pass, column pass, saturating product accumulation
// and output transform, queues the expected 2x2 tiles and compares every
// response field by field. Stimulus covers directed extremes, a long
// back-to-back tile at full scale, and random multi-slice tiles with random
// request gaps, response stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_winograd_f23_conv_tile;
   timeunit 1ns;
   timeprecision 1ps;

   import wf23_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT        = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 360;
   localparam int LONG_SLICES    = 16;
   localparam int REPORT_LIMIT   = 10;

   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   class winograd_tile_tracker;
      longint      row_pass[TILE_N-1][TILE_N];
      longint      weight_rows[TILE_N-1][TILE_N];
      longint      product_sums[ACC_N];
      row_idx_type row_cnt;
      rsp_type     predicted_tiles[$];
      int          mismatches;

      function new();
         row_cnt    = '0;
         mismatches = 0;
         foreach (product_sums[k]) product_sums[k] = 0;
      endfunction

      function longint clamp_acc(longint v);
         longint hi;
         longint lo;
         hi = ACC_MAX;
         lo = ACC_MIN;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function int a_coef(int i, int k);
         if (i == 0) return (k < 3) ? 1 : 0;
         return (k == 0) ? 0 : ((k == 1) ? 1 : -1);
      endfunction

      function int tiles_due();
         return predicted_tiles.size();
      endfunction

      function void note_request(req_type item);
         longint  s[TILE_N];
         longint  w[TILE_N];
         longint  r[TILE_N];
         longint  col[TILE_N];
         longint  wt;
         longint  sum;
         longint  outs[4];
         rsp_type tile;
         s[0] = item.sample_0;
         s[1] = item.sample_1;
         s[2] = item.sample_2;
         s[3] = item.sample_3;
         w[0] = item.weight_0;
         w[1] = item.weight_1;
         w[2] = item.weight_2;
         w[3] = item.weight_3;
         r[0] = s[0] - s[2];
         r[1] = s[1] + s[2];
         r[2] = s[2] - s[1];
         r[3] = s[1] - s[3];
         if (row_cnt != LAST_ROW) begin
            for (int c = 0; c < TILE_N; c++) begin
               row_pass[row_cnt][c]    = r[c];
               weight_rows[row_cnt][c] = w[c];
            end
            row_cnt++;
            return;
         end
         row_cnt = '0;
         for (int c = 0; c < TILE_N; c++) begin
            col[0] = row_pass[0][c] - row_pass[2][c];
            col[1] = row_pass[1][c] + row_pass[2][c];
            col[2] = row_pass[2][c] - row_pass[1][c];
            col[3] = row_pass[1][c] - r[c];
            for (int i = 0; i < TILE_N; i++) begin
               wt = (i < TILE_N - 1) ? weight_rows[i][c] : w[c];
               product_sums[i*TILE_N+c] =
                  clamp_acc(product_sums[i*TILE_N+c] + col[i] * wt);
            end
         end
         if (!item.last_slice) return;
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
               sum = item.bias;
               for (int rr = 0; rr < TILE_N; rr++) begin
                  for (int cc = 0; cc < TILE_N; cc++) begin
                     sum += a_coef(i, rr) * a_coef(j, cc) * product_sums[rr*TILE_N+cc];
                  end
               end
               outs[i*2+j] = clamp_acc(sum);
            end
         end
         tile.out_00 = acc_type'(outs[0]);
         tile.out_01 = acc_type'(outs[1]);
         tile.out_10 = acc_type'(outs[2]);
         tile.out_11 = acc_type'(outs[3]);
         predicted_tiles.push_back(tile);
         foreach (product_sums[k]) product_sums[k] = 0;
      endfunction

      function void log_mismatch(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%s: exp %0d %0d %0d %0d got %0d %0d %0d %0d", what,
                     want.out_00, want.out_01, want.out_10, want.out_11,
                     got.out_00, got.out_01, got.out_10, got.out_11);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (predicted_tiles.size() == 0) begin
            log_mismatch("unexpected tile", '0, got);
            return;
         end
         want = predicted_tiles.pop_front();
         if (got.out_00 !== want.out_00 || got.out_01 !== want.out_01 ||
             got.out_10 !== want.out_10 || got.out_11 !== want.out_11) begin
            log_mismatch("tile mismatch", want, got);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   winograd_tile_tracker board;
   bit quiet = 1'b0;
   int idle_cycles = 0;

   winograd_f23_conv_tile u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type make_row(data_type s0, data_type s1, data_type s2,
                                        data_type s3, data_type w0, data_type w1,
                                        data_type w2, data_type w3, acc_type bias,
                                        logic last);
      req_type item;
      item.sample_0   = s0;
      item.sample_1   = s1;
      item.sample_2   = s2;
      item.sample_3   = s3;
      item.weight_0   = w0;
      item.weight_1   = w1;
      item.weight_2   = w2;
      item.weight_3   = w3;
      item.bias       = bias;
      item.last_slice = last;
      return item;
   endfunction

   function automatic data_type draw_data();
      case ($urandom_range(0, 7))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return data_type'(int'($urandom_range(0, 8)) - 4);
         default: return data_type'($urandom);
      endcase
   endfunction

   function automatic acc_type draw_bias();
      case ($urandom_range(0, 7))
         0:       return ACC_MAX;
         1:       return ACC_MIN;
         2:       return acc_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return acc_type'({$urandom, $urandom});
      endcase
   endfunction

   function automatic req_type random_row();
      return make_row(draw_data(), draw_data(), draw_data(), draw_data(),
                      draw_data(), draw_data(), draw_data(), draw_data(),
                      draw_bias(), 1'($urandom_range(0, 1)));
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   initial begin : rsp_side
      int stall;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      wait (!reset);
      forever begin
         if (taken % 8 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 10);
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_result(rsp_payload);
         taken++;
      end
   end

   initial begin : stimulus
      req_type item;
      int      n_slices;
      int      sent;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // alternate full-scale rows, stray last marks on early rows
      for (int rw = 0; rw < TILE_N; rw++) begin
         item = (rw % 2 == 0)
            ? make_row(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                       DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, '0, 1'b1)
            : make_row(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                       DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, '0, 1'b1);
         send_request(item);
      end

      // saturate the output transform both ways through the bias
      for (int t = 0; t < 2; t++) begin
         for (int rw = 0; rw < TILE_N; rw++) begin
            item = (rw % 2 == 0)
               ? make_row(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX,
                          DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, ACC_MAX, 1'b0)
               : make_row(DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN,
                          DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, ACC_MAX, 1'b0);
            if (t == 1) begin
               item.weight_0 = DATA_MAX;
               item.weight_2 = DATA_MAX;
               item.bias     = ACC_MIN;
            end
            item.last_slice = (rw == TILE_N - 1);
            send_request(item);
         end
      end

      // two slices accumulate into one tile
      for (int rw = 0; rw < 2 * TILE_N; rw++) begin
         item = (rw < TILE_N)
            ? make_row('0, '0, '0, '0, DATA_MAX, DATA_MIN, '1, 16'sd1, '1, 1'b0)
            : make_row('1, 16'sd1, '1, 16'sd1, DATA_MIN, DATA_MAX, 16'sd1, '1, '1, 1'b0);
         item.last_slice = (rw == 2 * TILE_N - 1);
         send_request(item);
      end

      // zero samples with extreme weights
      for (int rw = 0; rw < TILE_N; rw++) begin
         item = make_row('0, '0, '0, '0, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX,
                         draw_bias(), 1'(rw != 1));
         send_request(item);
      end

      // long back-to-back multi-slice tile at full scale
      quiet = 1'b1;
      item  = make_row(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX,
                       DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, '0, 1'b0);
      for (int sl = 0; sl < LONG_SLICES; sl++) begin
         for (int rw = 0; rw < TILE_N; rw++) begin
            item.last_slice = (sl == LONG_SLICES - 1) && (rw == TILE_N - 1);
            send_request(item);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         n_slices = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8)
                                                : $urandom_range(1, 3);
         quiet = ($urandom_range(0, 3) == 0);
         for (int sl = 0; sl < n_slices; sl++) begin
            for (int rw = 0; rw < TILE_N; rw++) begin
               item = random_row();
               if (rw == TILE_N - 1) item.last_slice = (sl == n_slices - 1);
               send_request(item);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (board.tiles_due() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
